>>> hdl/gcss_pkg.sv
package gcss_pkg;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [2:0]  stop_index;
        logic [15:0] position;
        logic [7:0]  stop_red;
        logic [7:0]  stop_green;
        logic [7:0]  stop_blue;
        logic [7:0]  stop_alpha;
    } t_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rsp;

    typedef struct packed {
        logic [15:0] pos;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } t_stop;

    localparam int STOP_W = $bits(t_stop);

endpackage

>>> hdl/gradient_color_stop_sampler_unit.sv
// Gradient color stop sampler.
// Input channel (i_valid/o_ready, payload i_req): a write request loads one
// stop into the table and gives no result; a sample request returns one RGBA
// color on the output channel (o_valid/i_ready, o_rsp).
// Configuration: i_cfg_we with i_cfg_data sets the number of stops in use
// (0 acts as 1, values above MAX_STOPS act as MAX_STOPS). Write only when idle.
// A sample walks the stop table through the single read port of the table
// RAM, one entry a cycle: it fetches the last stop, then the first, then each
// further entry scanned. A clamped sample then goes to the output register;
// an interpolated one first passes a bit-serial divider and then one shared
// multiplier, used for each of the four channels in turn.
// One request is worked on at a time; o_ready is high only when idle.
// The result sits in an output register, so the next request is taken while
// it waits; a stalled receiver holds o_valid and o_rsp, and a later sample
// waits before its result until the register is free.
// Reset clears control state and sets the stop count to 1; the table is
// undefined until written.
module gradient_color_stop_sampler_unit
    import gcss_pkg::*;
#(
    parameter int MAX_STOPS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_req       i_req,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_STOPS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LAST = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_PUSH = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [3:0]    r_nstops;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [15:0]   r_pos, n_pos;
    t_stop         r_last, n_last;
    t_stop         r_prev, n_prev;
    t_stop         r_cur, n_cur;
    logic [15:0]   r_rem, n_rem;
    logic [15:0]   r_div, n_div;
    logic [15:0]   r_q, n_q;
    logic [3:0]    r_bit, n_bit;
    logic [1:0]    r_ch, n_ch;
    t_rsp          r_res, n_res;
    t_rsp          r_out;
    logic          r_ovalid;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_stop         ram_wdata, ram_rdata;
    logic [AW:0]   nclamp;
    logic [AW-1:0] last_idx;
    logic          acc;
    logic [16:0]   dtmp;
    logic [7:0]    c1, c2;
    logic signed [8:0]  diff;
    logic signed [25:0] prod;
    logic signed [26:0] total;
    logic          out_free;

    gcss_ram #(
        .WIDTH (STOP_W),
        .DEPTH (MAX_STOPS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_nstops == 4'd0) begin
            nclamp = (AW+1)'(1);
        end else if (32'(r_nstops) > MAX_STOPS) begin
            nclamp = (AW+1)'(MAX_STOPS);
        end else begin
            nclamp = (AW+1)'(r_nstops);
        end
    end
    assign last_idx = AW'(nclamp - (AW+1)'(1));

    assign o_ready  = (r_state == ST_IDLE);
    assign acc      = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;

    assign ram_we    = acc && (i_req.operation == OP_WRITE)
                       && (32'(i_req.stop_index) < MAX_STOPS);
    assign ram_waddr = AW'(i_req.stop_index);
    assign ram_wdata = '{pos: i_req.position, red: i_req.stop_red,
                         green: i_req.stop_green, blue: i_req.stop_blue,
                         alpha: i_req.stop_alpha};

    assign dtmp = {r_rem, 1'b0};

    always_comb begin
        case (r_ch)
            2'd0:    begin c1 = r_prev.red;   c2 = r_cur.red;   end
            2'd1:    begin c1 = r_prev.green; c2 = r_cur.green; end
            2'd2:    begin c1 = r_prev.blue;  c2 = r_cur.blue;  end
            default: begin c1 = r_prev.alpha; c2 = r_cur.alpha; end
        endcase
    end
    assign diff  = $signed({1'b0, c2}) - $signed({1'b0, c1});
    assign prod  = diff * $signed({1'b0, r_q});
    assign total = $signed({3'b000, c1, 16'h0000}) + $signed({prod[25], prod});

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_last    = r_last;
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_rem     = r_rem;
        n_div     = r_div;
        n_q       = r_q;
        n_bit     = r_bit;
        n_ch      = r_ch;
        n_res     = r_res;
        ram_raddr = r_cnt;
        case (r_state)
            ST_IDLE: begin
                ram_raddr = last_idx;
                if (acc && i_req.operation == OP_SAMPLE) begin
                    n_pos   = i_req.position;
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_last    = ram_rdata;
                ram_raddr = '0;
                n_cnt     = '0;
                n_state   = ST_SCAN;
            end
            ST_SCAN: begin
                ram_raddr = AW'(r_cnt + AW'(1));
                n_prev    = ram_rdata;
                n_cnt     = AW'(r_cnt + AW'(1));
                if (r_cnt == '0 && r_pos <= ram_rdata.pos) begin
                    n_res   = '{red: ram_rdata.red, green: ram_rdata.green,
                                blue: ram_rdata.blue, alpha: ram_rdata.alpha};
                    n_state = ST_PUSH;
                end else if (r_cnt == '0 && r_pos >= r_last.pos) begin
                    n_res   = '{red: r_last.red, green: r_last.green,
                                blue: r_last.blue, alpha: r_last.alpha};
                    n_state = ST_PUSH;
                end else if (r_cnt != '0 && r_pos < ram_rdata.pos) begin
                    n_prev  = r_prev;
                    n_cur   = ram_rdata;
                    n_rem   = r_pos - r_prev.pos;
                    n_div   = ram_rdata.pos - r_prev.pos;
                    n_bit   = '0;
                    n_state = ST_DIV;
                end else if (r_cnt == last_idx) begin
                    n_res   = '{red: r_last.red, green: r_last.green,
                                blue: r_last.blue, alpha: r_last.alpha};
                    n_state = ST_PUSH;
                end
            end
            ST_DIV: begin
                if (dtmp >= {1'b0, r_div}) begin
                    n_rem = 16'(dtmp - {1'b0, r_div});
                    n_q   = {r_q[14:0], 1'b1};
                end else begin
                    n_rem = dtmp[15:0];
                    n_q   = {r_q[14:0], 1'b0};
                end
                n_bit = r_bit + 4'd1;
                if (r_bit == 4'd15) begin
                    n_ch    = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                case (r_ch)
                    2'd0:    n_res.red   = total[23:16];
                    2'd1:    n_res.green = total[23:16];
                    2'd2:    n_res.blue  = total[23:16];
                    default: n_res.alpha = total[23:16];
                endcase
                n_ch = r_ch + 2'd1;
                if (r_ch == 2'd3) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_nstops <= 4'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_nstops <= i_cfg_data;
            end
            if (r_state == ST_PUSH && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_pos  <= n_pos;
        r_last <= n_last;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_q    <= n_q;
        r_bit  <= n_bit;
        r_ch   <= n_ch;
        r_res  <= n_res;
        if (r_state == ST_PUSH && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_ovalid;
    assign o_rsp   = r_out;

endmodule

>>> hdl/gcss_ram.sv
module gcss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> verif/testbench.sv
module testbench;
    import gcss_pkg::*;

    localparam int NUM_STOPS  = 8;
    localparam int SETTLE     = 40;
    localparam int CYCLE_CAP  = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_req       i_req;
    logic       o_valid;
    logic       i_ready;
    t_rsp       o_rsp;
    logic       i_cfg_we;
    logic [3:0] i_cfg_data;

    gradient_color_stop_sampler_unit #(.MAX_STOPS(NUM_STOPS)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_req        pending_reqs[$];
    t_rsp        expected_colors[$];
    t_stop       stop_copy[NUM_STOPS];
    logic [3:0]  count_copy;
    logic [15:0] gen_pos[NUM_STOPS];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_request;
    int          hold_left;
    int          errors;
    int          cycles;

    function automatic logic [7:0] blend_channel(logic [7:0] c1, logic [7:0] c2,
                                                 logic [16:0] frac);
        longint d;
        longint total;
        d = longint'(c2) - longint'(c1);
        total = longint'(c1) * 65536 + d * longint'(frac);
        if (total < 0) begin
            total = 0;
        end
        return total[23:16];
    endfunction

    function automatic t_rsp stop_color(t_stop s);
        t_rsp c;
        c.red   = s.red;
        c.green = s.green;
        c.blue  = s.blue;
        c.alpha = s.alpha;
        return c;
    endfunction

    function automatic t_rsp sample_gradient(logic [15:0] pos);
        int     n;
        int     i;
        longint num;
        longint frac;
        t_stop  lo;
        t_stop  hi;
        t_rsp   c;
        n = count_copy;
        if (n < 1) begin
            n = 1;
        end
        if (n > NUM_STOPS) begin
            n = NUM_STOPS;
        end
        if (pos <= stop_copy[0].pos) begin
            return stop_color(stop_copy[0]);
        end
        if (pos >= stop_copy[n-1].pos) begin
            return stop_color(stop_copy[n-1]);
        end
        for (i = 0; i < n; i++) begin
            if (pos < stop_copy[i].pos) begin
                break;
            end
        end
        if (i >= n || i == 0) begin
            return stop_color(stop_copy[n-1]);
        end
        lo = stop_copy[i-1];
        hi = stop_copy[i];
        if (hi.pos <= lo.pos || pos < lo.pos) begin
            return stop_color(stop_copy[n-1]);
        end
        num = longint'(pos - lo.pos) << 16;
        frac = num / longint'(hi.pos - lo.pos);
        if (frac > 65535) begin
            frac = 65535;
        end
        c.red   = blend_channel(lo.red,   hi.red,   frac[16:0]);
        c.green = blend_channel(lo.green, hi.green, frac[16:0]);
        c.blue  = blend_channel(lo.blue,  hi.blue,  frac[16:0]);
        c.alpha = blend_channel(lo.alpha, hi.alpha, frac[16:0]);
        return c;
    endfunction

    // request driver; predicts at acceptance
    always @(posedge i_clk) begin
        t_stop s;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                if (i_req.operation == OP_WRITE) begin
                    s.pos   = i_req.position;
                    s.red   = i_req.stop_red;
                    s.green = i_req.stop_green;
                    s.blue  = i_req.stop_blue;
                    s.alpha = i_req.stop_alpha;
                    stop_copy[i_req.stop_index] = s;
                end else begin
                    expected_colors.push_back(sample_gradient(i_req.position));
                end
            end
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_req   <= pending_reqs.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver with long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_request != 0 && hold_left == 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_request;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_request <= 0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_colors.size() == 0) begin
                $error("unexpected color %h", o_rsp);
                errors++;
            end else begin
                want = expected_colors.pop_front();
                if (o_rsp.red !== want.red) begin
                    $error("red: expected %0d actual %0d", want.red, o_rsp.red);
                    errors++;
                end
                if (o_rsp.green !== want.green) begin
                    $error("green: expected %0d actual %0d", want.green, o_rsp.green);
                    errors++;
                end
                if (o_rsp.blue !== want.blue) begin
                    $error("blue: expected %0d actual %0d", want.blue, o_rsp.blue);
                    errors++;
                end
                if (o_rsp.alpha !== want.alpha) begin
                    $error("alpha: expected %0d actual %0d", want.alpha, o_rsp.alpha);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic add_write(int idx, logic [15:0] pos, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic [7:0] a);
        t_req q;
        q.operation  = OP_WRITE;
        q.stop_index = idx[2:0];
        q.position   = pos;
        q.stop_red   = r;
        q.stop_green = g;
        q.stop_blue  = b;
        q.stop_alpha = a;
        gen_pos[idx] = pos;
        pending_reqs.push_back(q);
    endtask

    task automatic add_sample(logic [15:0] pos);
        t_req q;
        q = t_req'($urandom());
        q.operation = OP_SAMPLE;
        q.position  = pos;
        pending_reqs.push_back(q);
    endtask

    task automatic load_sorted_table();
        logic [15:0] p[$];
        int i;
        for (i = 0; i < NUM_STOPS; i++) begin
            case ($urandom_range(9))
                0: p.push_back(16'd0);
                1: p.push_back(16'hFFFF);
                default: p.push_back(16'($urandom()));
            endcase
        end
        p.sort();
        for (i = 0; i < NUM_STOPS; i++) begin
            add_write(i, p[i], 8'($urandom()), 8'($urandom()), 8'($urandom()),
                      8'($urandom()));
        end
    endtask

    task automatic drain_and_settle();
        while (pending_reqs.size() > 0 || i_valid || expected_colors.size() > 0
               || hold_left > 0 || hold_request != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_stop_count(logic [3:0] v);
        drain_and_settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        count_copy = v;
    endtask

    initial begin
        logic [3:0] counts[6];
        int ph;
        int k;
        int j;
        int r;
        counts = '{4'd0, 4'd15, 4'd3, 4'd8, 4'd1, 4'd5};
        errors        = 0;
        cycles        = 0;
        hold_request  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        count_copy    = 4'd1;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 4'd0;
        i_ready    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full sorted table with extreme colors, one stop in use
        add_write(0, 16'd0,     8'd0,   8'd255, 8'd0,   8'd255);
        add_write(1, 16'd1000,  8'd255, 8'd0,   8'd255, 8'd0);
        add_write(2, 16'd1000,  8'd10,  8'd20,  8'd30,  8'd40);
        add_write(3, 16'd20000, 8'd200, 8'd100, 8'd50,  8'd25);
        add_write(4, 16'd20001, 8'd0,   8'd0,   8'd0,   8'd0);
        add_write(5, 16'd40000, 8'd255, 8'd255, 8'd255, 8'd255);
        add_write(6, 16'd65534, 8'd1,   8'd2,   8'd3,   8'd4);
        add_write(7, 16'hFFFF,  8'd128, 8'd64,  8'd32,  8'd16);
        add_sample(16'd0);
        add_sample(16'hFFFF);
        add_sample(16'd500);

        set_stop_count(4'd8);
        add_sample(16'd0);
        add_sample(16'hFFFF);
        add_sample(16'd1);
        add_sample(16'd999);
        add_sample(16'd1000);
        add_sample(16'd10000);
        add_sample(16'd20000);
        add_sample(16'd30000);
        add_sample(16'd65534);
        // unsorted table
        add_write(3, 16'd100, 8'd9, 8'd9, 8'd9, 8'd9);
        add_sample(16'd20000);
        add_sample(16'd50);

        for (ph = 0; ph < 6; ph++) begin
            set_stop_count(counts[ph]);
            send_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 75 : 0;
            recv_idle_pct = (ph < 2) ? 75 : (ph < 4) ? 11 : 0;
            if (ph == 4) begin
                hold_request = 300;
            end
            load_sorted_table();
            k = 0;
            while (k < 96) begin
                r = $urandom_range(99);
                if (r < 6) begin
                    load_sorted_table();
                    k = k + NUM_STOPS - 1;
                end else if (r < 10) begin
                    add_write($urandom_range(NUM_STOPS - 1), 16'($urandom()),
                              8'($urandom()), 8'($urandom()), 8'($urandom()),
                              8'($urandom()));
                end else if (r < 35) begin
                    j = $urandom_range(NUM_STOPS - 1);
                    add_sample(gen_pos[j] + 16'($signed($urandom_range(4)) - 2));
                end else if (r < 40) begin
                    add_sample(($urandom_range(1) != 0) ? 16'hFFFF : 16'd0);
                end else begin
                    add_sample(16'($urandom()));
                end
                k++;
            end
        end

        drain_and_settle();
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
